>>> rtl/core/mm2_pkg.sv
// shared constants, types and helpers for the murmur2 hash engine
package mm2_pkg;

   localparam logic [31:0] MixMul    = 32'h5bd1_e995;
   localparam int unsigned MixShift  = 24;
   localparam int unsigned FinShiftA = 13;
   localparam int unsigned FinShiftB = 15;
   localparam logic [31:0] SeedReset = 32'd42;

   // one operation of the shared multiplier per cycle
   typedef enum logic [2:0] {
      OP_NONE,
      OP_KEY_MUL,
      OP_KEY_MIX,
      OP_HASH_FOLD,
      OP_TAIL,
      OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY_MUL,
      ST_KEY_MIX,
      ST_HASH_FOLD,
      ST_TAIL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic req_full;
      logic req_tail;
      logic req_last;
      logic item_last;
   } status_type;

   // keeps only the valid bytes of a word; counts of four and up keep all
   function automatic logic [31:0] word_mask(input logic [2:0] count);
      logic [31:0] mask;
      mask = '1;
      if (!count[2]) begin
         unique case (count[1:0])
            2'd0: mask = 32'h0000_0000;
            2'd1: mask = 32'h0000_00ff;
            2'd2: mask = 32'h0000_ffff;
            2'd3: mask = 32'h00ff_ffff;
            default: mask = 32'h0000_0000;
         endcase
      end
      return mask;
   endfunction

endpackage

>>> rtl/core/mm2_datapath.sv
// datapath: seed, running hash, word registers and the shared multiplier
module mm2_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [31:0]         csr_write_data,
   input  logic                req_first_item,
   input  logic [30:0]         req_key_length,
   input  logic [31:0]         req_data_word,
   input  logic [2:0]          req_byte_count,
   input  logic                req_last_item,
   input  mm2_pkg::cmd_type    cmd,
   output mm2_pkg::status_type status,
   output logic [31:0]         rsp_hash_value
);

   logic [31:0] seed_ff;
   logic [31:0] hash_ff;
   logic [31:0] hash_in;
   logic [31:0] word_ff;
   logic [31:0] key_ff;
   logic [31:0] result_ff;
   logic        last_ff;
   logic [31:0] mul_operand;
   logic [31:0] product;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mm2_pkg::SeedReset;
      end else if (csr_write_enable) begin
         seed_ff <= csr_write_data;
      end
   end

   // operand select for the one multiplier
   always_comb begin
      unique case (cmd.op)
         mm2_pkg::OP_KEY_MUL:   mul_operand = word_ff;
         mm2_pkg::OP_KEY_MIX:   mul_operand = key_ff ^ (key_ff >> mm2_pkg::MixShift);
         mm2_pkg::OP_HASH_FOLD: mul_operand = hash_ff;
         mm2_pkg::OP_TAIL:      mul_operand = hash_ff ^ word_ff;
         mm2_pkg::OP_FINISH:    mul_operand = hash_ff ^ (hash_ff >> mm2_pkg::FinShiftA);
         default:               mul_operand = '0;
      endcase
   end

   assign product = mul_operand * mm2_pkg::MixMul;

   always_comb begin
      hash_in = hash_ff;
      if (cmd.load) begin
         if (req_first_item) begin
            hash_in = seed_ff ^ {1'b0, req_key_length};
         end
      end else if (cmd.op == mm2_pkg::OP_HASH_FOLD) begin
         hash_in = product ^ key_ff;
      end else if (cmd.op == mm2_pkg::OP_TAIL) begin
         hash_in = product;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else begin
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         word_ff <= req_data_word & mm2_pkg::word_mask(req_byte_count);
         last_ff <= req_last_item;
      end
      if (cmd.op == mm2_pkg::OP_KEY_MUL || cmd.op == mm2_pkg::OP_KEY_MIX) begin
         key_ff <= product;
      end
      if (cmd.op == mm2_pkg::OP_FINISH) begin
         result_ff <= product;
      end
   end

   assign status.req_full  = req_byte_count[2];
   assign status.req_tail  = !req_byte_count[2] && (req_byte_count[1:0] != 2'd0);
   assign status.req_last  = req_last_item;
   assign status.item_last = last_ff;

   assign rsp_hash_value = result_ff ^ (result_ff >> mm2_pkg::FinShiftB);

endmodule

>>> rtl/core/mm2_ctrl.sv
// controller: sequences multiplier steps and owns the handshakes
module mm2_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  mm2_pkg::status_type status,
   output mm2_pkg::cmd_type    cmd
);

   mm2_pkg::state_type state_ff;
   mm2_pkg::state_type state_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               accept;
   logic               out_free;

   assign accept   = req_valid && (state_ff == mm2_pkg::ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mm2_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (status.req_full) begin
                  state_in = mm2_pkg::ST_KEY_MUL;
               end else if (status.req_tail) begin
                  state_in = mm2_pkg::ST_TAIL;
               end else if (status.req_last) begin
                  state_in = mm2_pkg::ST_FINISH;
               end else begin
                  state_in = mm2_pkg::ST_IDLE;
               end
            end
         end
         mm2_pkg::ST_KEY_MUL:   state_in = mm2_pkg::ST_KEY_MIX;
         mm2_pkg::ST_KEY_MIX:   state_in = mm2_pkg::ST_HASH_FOLD;
         mm2_pkg::ST_HASH_FOLD,
         mm2_pkg::ST_TAIL: begin
            state_in = status.item_last ? mm2_pkg::ST_FINISH : mm2_pkg::ST_IDLE;
         end
         mm2_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = mm2_pkg::ST_IDLE;
            end
         end
         default: state_in = mm2_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.load = 1'b0;
      cmd.op   = mm2_pkg::OP_NONE;
      unique case (state_ff)
         mm2_pkg::ST_IDLE:      cmd.load = accept;
         mm2_pkg::ST_KEY_MUL:   cmd.op   = mm2_pkg::OP_KEY_MUL;
         mm2_pkg::ST_KEY_MIX:   cmd.op   = mm2_pkg::OP_KEY_MIX;
         mm2_pkg::ST_HASH_FOLD: cmd.op   = mm2_pkg::OP_HASH_FOLD;
         mm2_pkg::ST_TAIL:      cmd.op   = mm2_pkg::OP_TAIL;
         mm2_pkg::ST_FINISH:    cmd.op   = out_free ? mm2_pkg::OP_FINISH : mm2_pkg::OP_NONE;
         default:               cmd.op   = mm2_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == mm2_pkg::ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mm2_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != mm2_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/murmur2_hash_engine.sv
// top level of the streaming 32-bit murmur2 hash engine
// steps: after the accept, a full word runs key multiply, key mix and hash fold on the
//   single 32x32 multiplier, a 1 to 3 byte tail runs the tail step, an empty word none;
//   the last beat adds the finish step; no new beat is taken until the steps of the
//   previous one are done, and finish waits while a pending result is stalled
// reset: synchronous active high; seed returns to 42, running hash to zero, no result pending
module murmur2_hash_engine (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   // key word beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_item,
   input  logic [30:0] req_key_length,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_last_item,
   // finished hash beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);

   mm2_pkg::cmd_type    cmd;
   mm2_pkg::status_type status;

   // controller walks through the multiply steps of one beat at a time:
   //   full word: key * m, mixed key * m, hash * m xor key
   //   tail: (hash xor masked bytes) * m
   //   finish: waits for the output register to free, then (hash xor hash>>13) * m
   mm2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds the seed register, the running hash and the result register;
   // a finished hash waiting downstream does not block the next key beat
   mm2_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_first_item   (req_first_item),
      .req_key_length   (req_key_length),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_last_item    (req_last_item),
      .cmd              (cmd),
      .status           (status),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

>>> rtl/core/mm2_checker.sv
// port-level checker for the murmur2 hash engine, bound to the top level
module mm2_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_byte_count,
   input logic        req_last_item,
   input logic        rsp_valid,
   input logic        rsp_stall
);

   logic req_beat;

   assign req_beat = req_valid && !req_stall;

   // a pending result is held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a non-last beat never produces a result by itself
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat && !req_last_item && !rsp_valid |=> !rsp_valid)
      else $error("result appeared after a non-last beat");

   // an empty non-last beat leaves the engine ready for a new beat in the cycle after it
   a_empty_beat_fast: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_byte_count == 3'd0 && !req_last_item |=> !req_stall)
      else $error("empty beat kept the engine busy");

   // a full word keeps the engine stalled through its key multiply and key mix steps
   a_full_word_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_byte_count[2] |=> req_stall ##1 req_stall)
      else $error("full word finished too early");

endmodule

bind murmur2_hash_engine mm2_checker u_mm2_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_byte_count (req_byte_count),
   .req_last_item  (req_last_item),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the streaming murmur2 hash engine
module testbench;

   localparam int SettleCycles = 8;        // longest in-flight word plus finish, with margin
   localparam int CycleLimit   = 200000;   // far above the slowest legal run
   localparam int PhaseBeats   = 200;      // useful random beats per seed setting

   // one key word beat as queued for the driver
   typedef struct {
      logic        first;
      logic [30:0] key_len;
      logic [31:0] word;
      logic [2:0]  count;
      logic        last;
      logic        drain_first;   // hold this beat until no hash is outstanding
   } key_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_first_item = 1'b0;
   logic [30:0] req_key_length = '0;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_hash_value;

   key_beat_type beat_queue[$];
   key_beat_type next_beat;
   logic [31:0]  expected_hashes[$];
   logic [31:0]  want_hash;

   // shadow copy of the engine state
   logic [31:0] model_seed;
   logic [31:0] model_hash;

   logic        beat_taken = 1'b0;
   logic        hold_next = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          beats_queued = 0;
   int          beats_accepted = 0;
   int          useful_beats = 0;
   int          hashes_checked = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   logic [31:0] last_seed;

   murmur2_hash_engine u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_item   (req_first_item),
      .req_key_length   (req_key_length),
      .req_data_word    (req_data_word),
      .req_byte_count   (req_byte_count),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one word step of the running hash: full word mix and fold, tail xor and multiply,
   // or nothing for an empty word
   function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] w,
                                             input logic [2:0] n);
      logic [31:0] k;
      logic [31:0] keep;
      if (n >= 3'd4) begin
         k = w * mm2_pkg::MixMul;
         k = k ^ (k >> mm2_pkg::MixShift);
         k = k * mm2_pkg::MixMul;
         return (h * mm2_pkg::MixMul) ^ k;
      end
      if (n != 3'd0) begin
         keep = (32'h1 << (8 * n)) - 32'h1;
         return (h ^ (w & keep)) * mm2_pkg::MixMul;
      end
      return h;
   endfunction

   // final avalanche applied to a copy of the running hash
   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] x;
      x = h ^ (h >> mm2_pkg::FinShiftA);
      x = x * mm2_pkg::MixMul;
      return x ^ (x >> mm2_pkg::FinShiftB);
   endfunction

   // driver: payload changes at the falling edge, only once the previous beat was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (beat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct &&
             !(beat_queue[0].drain_first && expected_hashes.size() > 0)) begin
            next_beat = beat_queue.pop_front();
            req_valid      <= 1'b1;
            req_first_item <= next_beat.first;
            req_key_length <= next_beat.key_len;
            req_data_word  <= next_beat.word;
            req_byte_count <= next_beat.count;
            req_last_item  <= next_beat.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
      // receiver back-pressure, independent of anything else
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: predicts on every accepted word beat, checks every accepted hash beat
   always @(posedge clock) begin
      if (reset) begin
         beat_taken <= 1'b0;
         model_seed = mm2_pkg::SeedReset;
         model_hash = '0;
      end else begin
         beat_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            beats_accepted++;
            // start, then word step, then finish, all within one beat
            if (req_first_item) model_hash = model_seed ^ {1'b0, req_key_length};
            model_hash = fold_word(model_hash, req_data_word, req_byte_count);
            if (req_last_item) expected_hashes.push_back(avalanche(model_hash));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_hashes.size() == 0) begin
               $error("hash_value beat with none expected: actual %08h", rsp_hash_value);
               error_count++;
            end else begin
               want_hash = expected_hashes.pop_front();
               hashes_checked++;
               if (rsp_hash_value !== want_hash) begin
                  $error("hash_value mismatch: expected %08h, actual %08h",
                         want_hash, rsp_hash_value);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) model_seed = csr_write_data;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("run stopped by watchdog after %0d cycles", CycleLimit);
         $display("Mismatches found");
         $finish;
      end
   end

   // queue one beat; empty middle beats do nothing and are not counted as useful
   task automatic add_beat(input logic first, input logic [30:0] key_len,
                           input logic [31:0] word, input logic [2:0] count,
                           input logic last);
      key_beat_type b;
      b.first       = first;
      b.key_len     = key_len;
      b.word        = word;
      b.count       = count;
      b.last        = last;
      b.drain_first = hold_next;
      hold_next     = 1'b0;
      beat_queue.push_back(b);
      beats_queued++;
      if (first || last || count != 3'd0) useful_beats++;
   endtask

   // a key of len bytes: full words first, then a tail beat if any bytes remain;
   // claimed is the length carried on the start beat
   task automatic add_key(input int unsigned len, input logic [30:0] claimed,
                          input bit with_first, input bit with_last);
      int unsigned left;
      int unsigned n;
      logic        start;
      logic [2:0]  count;
      left  = len;
      start = with_first;
      do begin
         n = (left >= 4) ? 4 : left;
         left -= n;
         count = n[2:0];
         // a count above four is also a full word
         if (n == 4 && $urandom_range(7) == 0) count = 3'(4 + $urandom_range(1, 3));
         add_beat(start, start ? claimed : 31'($urandom), $urandom, count,
                  with_last && left == 0);
         start = 1'b0;
      end while (left > 0);
   endtask

   // mostly well-formed keys with random content, some broken keys and loose beats
   task automatic random_phase(input int target);
      int          start_count;
      int          pick;
      int unsigned len;
      start_count = useful_beats;
      hold_next   = 1'b1;
      while (useful_beats - start_count < target) begin
         pick = $urandom_range(99);
         len  = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
         if ($urandom_range(39) == 0) hold_next = 1'b1;
         if (pick < 80)      add_key(len, 31'(len), 1'b1, 1'b1);
         else if (pick < 85) add_key(len, 31'($urandom), 1'b1, 1'b1);  // wrong length
         else if (pick < 90) add_key(len, 31'(len), 1'b1, 1'b0);       // abandoned key
         else if (pick < 94) add_key(len, 31'(len), 1'b0, 1'b1);       // no start beat
         else add_beat(1'($urandom_range(1)), 31'($urandom), $urandom,
                       3'($urandom_range(7)), 1'($urandom_range(1)));
      end
   endtask

   // all beats taken, all hashes back, then let any trailing word work finish
   task automatic wait_quiet();
      while (beats_accepted != beats_queued || expected_hashes.size() != 0)
         @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed beats under the reset seed
      send_idle_pct = 29;
      stall_pct     = 56;
      // no start beat right after reset: folds into a zero hash
      add_beat(1'b0, 31'd0, 32'h0000_0000, 3'd4, 1'b1);
      // empty key, start and finish on the same beat
      add_beat(1'b1, 31'd0, 32'h0000_0000, 3'd0, 1'b1);
      // largest length and all-ones word
      add_beat(1'b1, 31'h7fff_ffff, 32'hffff_ffff, 3'd4, 1'b1);
      // three byte tail with the unused top byte set
      add_beat(1'b1, 31'd7, 32'hffff_ffff, 3'd4, 1'b0);
      add_beat(1'b0, 31'd0, 32'hffff_ffff, 3'd3, 1'b1);
      // one and two byte keys
      add_beat(1'b1, 31'd1, 32'hdead_beef, 3'd1, 1'b1);
      add_beat(1'b1, 31'd2, 32'h0000_0000, 3'd2, 1'b1);
      // counts five to seven act as full words
      add_beat(1'b1, 31'd12, 32'h1234_5678, 3'd5, 1'b0);
      add_beat(1'b0, 31'd0, 32'h8765_4321, 3'd6, 1'b0);
      add_beat(1'b0, 31'd0, 32'hcafe_f00d, 3'd7, 1'b1);
      // empty words leave the hash alone, also on the start and last beats
      add_beat(1'b1, 31'd4, 32'h5555_5555, 3'd0, 1'b0);
      add_beat(1'b0, 31'd0, 32'ha5a5_a5a5, 3'd4, 1'b0);
      add_beat(1'b0, 31'd0, 32'hffff_ffff, 3'd0, 1'b1);
      // tail in the middle of a key, stream continues from it
      add_beat(1'b1, 31'd9, 32'h0000_beef, 3'd2, 1'b0);
      add_beat(1'b0, 31'd0, 32'h0102_0304, 3'd4, 1'b0);
      add_beat(1'b0, 31'd0, 32'h00ab_cdef, 3'd3, 1'b1);
      // after a finished key the unfinished hash is kept;
      // the sender waits here until the previous hash has come back
      hold_next = 1'b1;
      add_beat(1'b0, 31'd0, 32'h7777_7777, 3'd4, 1'b1);
      // length is only taken on the start beat
      add_beat(1'b1, 31'h2aaa_aaaa, 32'haaaa_aaaa, 3'd4, 1'b0);
      add_beat(1'b0, 31'h5555_5555, 32'h5555_5555, 3'd4, 1'b1);
      wait_quiet();

      // phase one: zero seed, sender idles less than receiver stalls
      write_seed(32'h0000_0000);
      @(posedge clock);
      random_phase(PhaseBeats);
      wait_quiet();

      // phase two: all-ones seed, roles of idling swapped
      write_seed(32'hffff_ffff);
      @(posedge clock);
      send_idle_pct = 56;
      stall_pct     = 29;
      random_phase(PhaseBeats);
      wait_quiet();

      // phase three: random seed, full speed on both sides
      last_seed = $urandom;
      write_seed(last_seed);
      @(posedge clock);
      send_idle_pct = 0;
      stall_pct     = 0;
      random_phase(PhaseBeats);
      wait_quiet();

      $display("sent %0d key word beats, checked %0d hashes", beats_accepted, hashes_checked);
      $display("seeds used: 42, 0, ffffffff, %08h; idle and stall mixes varied", last_seed);
      if (error_count == 0 && expected_hashes.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/mm2_pkg.sv
rtl/core/mm2_datapath.sv
rtl/core/mm2_ctrl.sv
rtl/core/murmur2_hash_engine.sv
rtl/core/mm2_checker.sv
tb/testbench.sv
